// ===== hdl/qn_pkg.sv =====
// ----------------------------------------------------------------------------
// qn_pkg: shared constants and types for the quaternion normalizer
// Widths of the components, the square root and the divider pipelines.
// ----------------------------------------------------------------------------
`default_nettype none

package qn_pkg;

   localparam int NCOMP       = 4;
   localparam int COMP_W      = 32;                  // Q16.16 in, Q2.30 out
   localparam int ABS_W       = 32;                  // magnitude up to 2^31
   localparam int LEAD_W      = 5;                   // bit position 0..31
   localparam int NORM_W      = 30;                  // normalized magnitude
   localparam int NORM_TOP    = 29;                  // target leading bit
   localparam int SQ_W        = 2 * NORM_W;          // one square
   localparam int RAD_W       = 64;                  // radicand 4*S
   localparam int ROOT_W      = RAD_W / 2;           // floor sqrt width
   localparam int SQRT_STAGES = ROOT_W;              // one root bit per stage
   localparam int QUO_W       = 31;                  // quotient < 2^31
   localparam int DIV_STAGES  = QUO_W;               // one quotient bit per stage
   localparam int FRONT_STAGES = 4;                  // abs, shift, square, sum
   localparam int PIPE_DEPTH  = FRONT_STAGES + SQRT_STAGES + DIV_STAGES;

   typedef logic [NORM_W-1:0] norm_type;
   typedef logic [ROOT_W-1:0] root_type;
   typedef logic [QUO_W-1:0]  quo_type;

   // Signs and the zero flag follow each item down the pipeline
   typedef struct packed {
      logic [NCOMP-1:0] neg;
      logic             zero;
   } side_type;

endpackage

`default_nettype wire

// ===== hdl/qn_req_if.sv =====
// ----------------------------------------------------------------------------
// qn_req_if: request channel carrying one Q16.16 quaternion
// Valid/ready handshake; an item moves when both are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface qn_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] in_w;
   logic signed [31:0] in_x;
   logic signed [31:0] in_y;
   logic signed [31:0] in_z;

   modport source (output valid, in_w, in_x, in_y, in_z, input ready);
   modport sink   (input valid, in_w, in_x, in_y, in_z, output ready);
endinterface

`default_nettype wire

// ===== hdl/qn_rsp_if.sv =====
// ----------------------------------------------------------------------------
// qn_rsp_if: response channel carrying one Q2.30 unit quaternion
// Valid/ready handshake; an item moves when both are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface qn_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_w;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;
   logic               zero_magnitude;

   modport source (output valid, out_w, out_x, out_y, out_z, zero_magnitude,
                   input ready);
   modport sink   (input valid, out_w, out_x, out_y, out_z, zero_magnitude,
                   output ready);
endinterface

`default_nettype wire

// ===== hdl/qn_sqrt.sv =====
// ----------------------------------------------------------------------------
// qn_sqrt: pipelined integer square root
// Restoring digit-by-digit root, one result bit per stage, floor(sqrt(v)).
// ----------------------------------------------------------------------------
`default_nettype none

module qn_sqrt (
   input  wire logic                      clock,
   input  wire logic                      advance,
   input  wire logic [qn_pkg::RAD_W-1:0]  radicand,
   output qn_pkg::root_type               root
);

   localparam int REM_W = qn_pkg::ROOT_W + 1;

   logic [REM_W-1:0]          rem_ff  [qn_pkg::SQRT_STAGES];
   qn_pkg::root_type          root_ff [qn_pkg::SQRT_STAGES];
   logic [qn_pkg::RAD_W-1:0]  val_ff  [qn_pkg::SQRT_STAGES];

   for (genvar s = 0; s < qn_pkg::SQRT_STAGES; s++) begin : g_stage
      logic [REM_W-1:0]         rem_prev;
      qn_pkg::root_type         root_prev;
      logic [qn_pkg::RAD_W-1:0] val_prev;
      logic [REM_W+1:0]         cur;
      logic [REM_W+1:0]         trial;
      logic                     take;

      if (s == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign val_prev  = radicand;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
         assign val_prev  = val_ff[s-1];
      end

      // bring down two radicand bits, try (4*root + 1)
      assign cur   = {rem_prev, val_prev[qn_pkg::RAD_W-1 -: 2]};
      assign trial = {1'b0, root_prev, 2'b01};
      assign take  = (cur >= trial);

      always_ff @(posedge clock) begin
         if (advance) begin
            if (take) begin
               rem_ff[s]  <= REM_W'(cur - trial);
               root_ff[s] <= {root_prev[qn_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff[s]  <= REM_W'(cur);
               root_ff[s] <= {root_prev[qn_pkg::ROOT_W-2:0], 1'b0};
            end
            val_ff[s] <= {val_prev[qn_pkg::RAD_W-3:0], 2'b00};
         end
      end
   end

   assign root = root_ff[qn_pkg::SQRT_STAGES-1];

endmodule

`default_nettype wire

// ===== hdl/qn_div_lane.sv =====
// ----------------------------------------------------------------------------
// qn_div_lane: pipelined rounding divider for one component
// Computes floor((a * 2^31 + R/2) / R), one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qn_div_lane (
   input  wire logic              clock,
   input  wire logic              advance,
   input  qn_pkg::norm_type       mag,
   input  qn_pkg::root_type       root,
   output qn_pkg::quo_type        quo
);

   localparam int REM_W = qn_pkg::ROOT_W;

   logic [REM_W-1:0]   rem_ff  [qn_pkg::DIV_STAGES];
   qn_pkg::root_type   root_ff [qn_pkg::DIV_STAGES];
   qn_pkg::quo_type    quo_ff  [qn_pkg::DIV_STAGES];

   for (genvar s = 0; s < qn_pkg::DIV_STAGES; s++) begin : g_stage
      logic [REM_W-1:0]   rem_prev;
      qn_pkg::root_type   root_prev;
      qn_pkg::quo_type    quo_prev;
      logic [REM_W:0]     cur;
      logic               take;

      // numerator high part is the magnitude; low 31 bits are R/2
      if (s == 0) begin : g_first
         assign rem_prev  = REM_W'(mag);
         assign root_prev = root;
         assign quo_prev  = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
         assign quo_prev  = quo_ff[s-1];
      end

      assign cur  = {rem_prev, root_prev[qn_pkg::DIV_STAGES - s]};
      assign take = (cur >= {1'b0, root_prev});

      always_ff @(posedge clock) begin
         if (advance) begin
            if (take) begin
               rem_ff[s] <= REM_W'(cur - {1'b0, root_prev});
            end else begin
               rem_ff[s] <= REM_W'(cur);
            end
            quo_ff[s]  <= {quo_prev[qn_pkg::QUO_W-2:0], take};
            root_ff[s] <= root_prev;
         end
      end
   end

   assign quo = quo_ff[qn_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== hdl/quaternion_normalize.sv =====
// ----------------------------------------------------------------------------
// quaternion_normalize: fixed-point unit quaternion
// Four Q16.16 components in, four Q2.30 components and a zero flag out.
// ----------------------------------------------------------------------------
//  channel   direction  payload                               handshake
//  req_chan  in         in_w, in_x, in_y, in_z (Q16.16)       valid/ready
//  rsp_chan  out        out_w..out_z (Q2.30), zero_magnitude  valid/ready
//
//  One item per cycle unless held; pipeline of 4 front stages (abs, shift,
//  square, sum), 32 square root stages, 31 divider stages, one output stage.
//  The whole pipeline moves together; it holds when a result waits unread.
//  Reset clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_normalize (
   input  wire logic  clock,
   input  wire logic  reset,
   qn_req_if.sink     req_chan,
   qn_rsp_if.source   rsp_chan
);

   localparam int NC = qn_pkg::NCOMP;
   localparam int SIDE_DEPTH = qn_pkg::SQRT_STAGES + qn_pkg::DIV_STAGES;

   logic advance;
   logic [qn_pkg::PIPE_DEPTH-1:0] vld_ff;
   logic rsp_valid_ff;

   // global pipeline enable
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= {vld_ff[qn_pkg::PIPE_DEPTH-2:0], req_chan.valid};
         rsp_valid_ff <= vld_ff[qn_pkg::PIPE_DEPTH-1];
      end
   end

   // stage 0: sign and magnitude, leading bit of the largest magnitude
   logic [31:0]               raw [NC];
   logic [qn_pkg::ABS_W-1:0]  abs_in [NC];
   logic [NC-1:0]             neg_in;
   logic [qn_pkg::ABS_W-1:0]  or_all;
   logic [qn_pkg::LEAD_W-1:0] lead_in;

   assign raw[0] = req_chan.in_w;
   assign raw[1] = req_chan.in_x;
   assign raw[2] = req_chan.in_y;
   assign raw[3] = req_chan.in_z;

   always_comb begin
      or_all = '0;
      for (int i = 0; i < NC; i++) begin
         neg_in[i] = raw[i][31];
         abs_in[i] = neg_in[i] ? (32'd0 - raw[i]) : raw[i];
         or_all    = or_all | abs_in[i];
      end
      lead_in = '0;
      for (int b = 0; b < qn_pkg::ABS_W; b++) begin
         if (or_all[b]) begin
            lead_in = qn_pkg::LEAD_W'(b);
         end
      end
   end

   logic [qn_pkg::ABS_W-1:0]  abs_ff [NC];
   logic [qn_pkg::LEAD_W-1:0] lead_ff;
   qn_pkg::side_type          s0_side_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         abs_ff             <= abs_in;
         lead_ff            <= lead_in;
         s0_side_ff.neg     <= neg_in;
         s0_side_ff.zero    <= (or_all == '0);
      end
   end

   // stage 1: common shift to put the leading bit at bit 29
   qn_pkg::norm_type norm_in [NC];
   logic [qn_pkg::ABS_W-1:0] sh_tmp [NC];

   always_comb begin
      for (int i = 0; i < NC; i++) begin
         if (lead_ff < qn_pkg::LEAD_W'(qn_pkg::NORM_TOP)) begin
            sh_tmp[i] = abs_ff[i] << (qn_pkg::LEAD_W'(qn_pkg::NORM_TOP) - lead_ff);
         end else begin
            sh_tmp[i] = abs_ff[i] >> (lead_ff - qn_pkg::LEAD_W'(qn_pkg::NORM_TOP));
         end
         norm_in[i] = sh_tmp[i][qn_pkg::NORM_W-1:0];
      end
   end

   qn_pkg::norm_type s1_norm_ff [NC];
   qn_pkg::side_type s1_side_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_norm_ff <= norm_in;
         s1_side_ff <= s0_side_ff;
      end
   end

   // stage 2: square each lane
   logic [qn_pkg::SQ_W-1:0] sq_ff [NC];
   qn_pkg::norm_type        s2_norm_ff [NC];
   qn_pkg::side_type        s2_side_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < NC; i++) begin
            sq_ff[i] <= s1_norm_ff[i] * s1_norm_ff[i];
         end
         s2_norm_ff <= s1_norm_ff;
         s2_side_ff <= s1_side_ff;
      end
   end

   // stage 3: merge lanes into the radicand 4*S
   logic [qn_pkg::SQ_W+1:0]  sum_in;
   logic [qn_pkg::RAD_W-1:0] rad_ff;
   qn_pkg::norm_type         s3_norm_ff [NC];
   qn_pkg::side_type         s3_side_ff;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NC; i++) begin
         sum_in = sum_in + (qn_pkg::SQ_W+2)'(sq_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rad_ff     <= {sum_in, 2'b00};
         s3_norm_ff <= s2_norm_ff;
         s3_side_ff <= s2_side_ff;
      end
   end

   // square root
   qn_pkg::root_type root;

   qn_sqrt u_sqrt (
      .clock    (clock),
      .advance  (advance),
      .radicand (rad_ff),
      .root     (root)
   );

   // delay magnitudes alongside the root, flags alongside root and divide
   qn_pkg::norm_type mag_dly_ff [qn_pkg::SQRT_STAGES][NC];
   qn_pkg::side_type side_dly_ff [SIDE_DEPTH];

   always_ff @(posedge clock) begin
      if (advance) begin
         mag_dly_ff[0]  <= s3_norm_ff;
         side_dly_ff[0] <= s3_side_ff;
         for (int d = 1; d < qn_pkg::SQRT_STAGES; d++) begin
            mag_dly_ff[d] <= mag_dly_ff[d-1];
         end
         for (int d = 1; d < SIDE_DEPTH; d++) begin
            side_dly_ff[d] <= side_dly_ff[d-1];
         end
      end
   end

   // divider lanes
   qn_pkg::quo_type quo [NC];

   for (genvar i = 0; i < NC; i++) begin : g_lane
      qn_div_lane u_div (
         .clock   (clock),
         .advance (advance),
         .mag     (mag_dly_ff[qn_pkg::SQRT_STAGES-1][i]),
         .root    (root),
         .quo     (quo[i])
      );
   end

   // output stage: clamp, apply sign, force zero result
   qn_pkg::side_type side_end;
   logic [31:0]      res_in [NC];
   logic [31:0]      res_ff [NC];
   logic             zero_ff;
   logic [31:0]      q_ext;

   assign side_end = side_dly_ff[SIDE_DEPTH-1];

   always_comb begin
      for (int i = 0; i < NC; i++) begin
         q_ext = {1'b0, quo[i]};
         if (q_ext > 32'h4000_0000) begin
            q_ext = 32'h4000_0000;
         end
         if (side_end.zero) begin
            res_in[i] = '0;
         end else if (side_end.neg[i]) begin
            res_in[i] = 32'd0 - q_ext;
         end else begin
            res_in[i] = q_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff  <= res_in;
         zero_ff <= side_end.zero;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.out_w          = res_ff[0];
   assign rsp_chan.out_x          = res_ff[1];
   assign rsp_chan.out_y          = res_ff[2];
   assign rsp_chan.out_z          = res_ff[3];
   assign rsp_chan.zero_magnitude = zero_ff;

endmodule

`default_nettype wire
